@@ rtl/msu_pkg.sv @@
// Types and constants shared by the shuffled minimal-standard generator.
// No dependencies; compiled first.
package msu_pkg;

  localparam int unsigned WordW      = 31;
  localparam int unsigned StateW     = 32;
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned ProdW      = 46;
  localparam int unsigned DblW       = 54;
  localparam int unsigned FloatW     = 30;
  localparam int unsigned ShW        = 5;

  localparam logic [WordW-1:0]  LehmerMod  = 31'h7FFF_FFFF;
  localparam logic [14:0]       LehmerMul  = 15'd16807;
  // First word whose scaled value lies above the clamp level.
  localparam logic [WordW-1:0]  ClampWord  = 31'd2147483390;
  localparam logic [FloatW-1:0] ClampBits  = 30'h3F7F_FFFE;
  localparam logic [7:0]        ExpBase    = 8'd126;

  typedef enum logic [2:0] {
    StIdle,
    StRMul,
    StRRed,
    StDMul,
    StDRed,
    StNorm,
    StRnd1,
    StOut
  } state_e;

  typedef struct packed {
    logic            ld_seed;
    logic            init_seed;
    logic            mul;
    logic            red;
    logic            rd;
    logic            wr_refill;
    logic            wr_draw;
    logic            last_from_s;
    logic            norm;
    logic [2:0]      norm_k;
    logic            rnd1;
    logic            out_load;
    logic [IdxW-1:0] waddr;
  } dp_cmd_t;

  typedef struct packed {
    logic need_init;
    logic out_stall;
  } dp_status_t;

endpackage

@@ rtl/msu_if.sv @@
// Valid/ready channel interfaces for commands and results.
// No dependencies; field widths are written out.
interface msu_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] seed_value;
  modport source (output valid, command, seed_value, input ready);
  modport sink (input valid, command, seed_value, output ready);
endinterface

interface msu_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] random_word;
  logic [29:0] unit_float_bits;
  modport source (output valid, random_word, unit_float_bits, input ready);
  modport sink (input valid, random_word, unit_float_bits, output ready);
endinterface

@@ rtl/minstd_shuffle_unit_random.sv @@
// Shuffled minimal-standard random source: x <- 16807*x mod (2^31-1) feeding
// a 32-entry shuffle table. Command 1 loads a seed in one transfer (no
// result); command 0 draws one word, returned with the single-precision bits
// of word/(2^31-1), clamped just below 1. A draw passes through the accepting
// cycle, the multiply with the table read, the reduce with the table write,
// a five-step leading-zero search, one rounding step and the result load
// with the final rounding.
// The first draw after a seed, or whenever the state is not positive,
// rebuilds the table first: WarmupSteps+32 generator steps, each a multiply
// and a reduce through the single multiplier. The result register frees
// the generator while a result waits; a new draw stalls only at its load.
// Depends on msu_pkg, msu_if, msu_ram, msu_ctrl and msu_dp.
module minstd_shuffle_unit_random #(
  parameter int unsigned WarmupSteps = 8
) (
  input logic     clk_i,
  input logic     rst_ni,
  msu_in_if.sink  in_chan,
  msu_out_if.source out_chan
);
  import msu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  msu_ctrl #(
    .WarmupSteps (WarmupSteps)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_chan.valid),
    .in_command_i (in_chan.command),
    .in_ready_o   (in_chan.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  msu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .seed_i      (in_chan.seed_value),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .word_o      (out_chan.random_word),
    .bits_o      (out_chan.unit_float_bits)
  );
endmodule

@@ rtl/msu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ rtl/msu_ctrl.sv @@
// Sequencer: refill loop, draw step, normalise and round steps.
// Depends on msu_pkg.
module msu_ctrl #(
  parameter int unsigned WarmupSteps = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_ready_o,
  input  msu_pkg::dp_status_t status_i,
  output msu_pkg::dp_cmd_t    cmd_o
);
  import msu_pkg::*;

  localparam int unsigned Steps = WarmupSteps + TableDepth;
  localparam int unsigned CntW  = $clog2(Steps);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      k_q, k_d;
  logic [CntW-1:0] off;
  logic            accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign off        = cnt_q - CntW'(WarmupSteps);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.norm_k = k_q;
    cmd_o.waddr  = IdxW'(TableDepth - 1) - off[IdxW-1:0];
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_command_i) begin
            cmd_o.ld_seed = 1'b1;
          end else if (status_i.need_init) begin
            cmd_o.init_seed = 1'b1;
            cnt_d   = '0;
            state_d = StRMul;
          end else begin
            state_d = StDMul;
          end
        end
      end
      StRMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StRRed;
      end
      StRRed: begin
        cmd_o.red       = 1'b1;
        cmd_o.wr_refill = (cnt_q >= CntW'(WarmupSteps));
        if (cnt_q == CntW'(Steps - 1)) begin
          cmd_o.last_from_s = 1'b1;
          state_d = StDMul;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = StRMul;
        end
      end
      StDMul: begin
        cmd_o.mul = 1'b1;
        cmd_o.rd  = 1'b1;
        state_d   = StDRed;
      end
      StDRed: begin
        cmd_o.red     = 1'b1;
        cmd_o.wr_draw = 1'b1;
        k_d     = 3'd4;
        state_d = StNorm;
      end
      StNorm: begin
        cmd_o.norm = 1'b1;
        if (k_q == 3'd0) begin
          state_d = StRnd1;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      StRnd1: begin
        cmd_o.rnd1 = 1'b1;
        state_d    = StOut;
      end
      StOut: begin
        if (!status_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

@@ rtl/msu_dp.sv @@
// Datapath: generator state, modular multiply, shuffle table, float conversion
// and the result register. Depends on msu_pkg and msu_ram.
module msu_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  msu_pkg::dp_cmd_t           cmd_i,
  output msu_pkg::dp_status_t        status_o,
  input  logic [msu_pkg::StateW-1:0] seed_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [msu_pkg::WordW-1:0]  word_o,
  output logic [msu_pkg::FloatW-1:0] bits_o
);
  import msu_pkg::*;

  logic [StateW-1:0] s_q, s_d;
  logic [WordW-1:0]  last_q, last_d;
  logic [ProdW-1:0]  prod_q;
  logic [WordW-1:0]  norm_q, norm_d;
  logic [ShW-1:0]    sh_q, sh_d;
  logic [DblW-1:0]   d_q;
  logic              out_valid_q;
  logic [WordW-1:0]  word_q;
  logic [FloatW-1:0] bits_q;

  logic [StateW-1:0] sum;
  logic [WordW-1:0]  red;
  logic [StateW-1:0] neg;
  logic [WordW-1:0]  rdata;
  logic [IdxW-1:0]   idx;
  logic [ShW-1:0]    amt;
  logic [52:0]       top53;
  logic              inc1;
  logic [23:0]       keep24;
  logic              inc2;
  logic [24:0]       m25;
  logic [7:0]        expo;
  logic [FloatW-1:0] fbits;

  // Fold 2^31 == 1 mod 2^31-1, then one conditional subtract.
  assign sum = {17'b0, prod_q[ProdW-1:WordW]} + {1'b0, prod_q[WordW-1:0]};
  assign red = (sum >= {1'b0, LehmerMod}) ? WordW'(sum - {1'b0, LehmerMod})
                                          : sum[WordW-1:0];
  assign neg = '0 - s_q;
  assign idx = last_q[WordW-1 -: IdxW];

  assign status_o.need_init = (s_q == '0) || s_q[StateW-1] || (last_q == '0);
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  msu_ram #(
    .Width (WordW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_refill || cmd_i.wr_draw),
    .waddr_i (cmd_i.wr_refill ? cmd_i.waddr : idx),
    .wdata_i (red),
    .re_i    (cmd_i.rd),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_comb begin
    s_d = s_q;
    if (cmd_i.ld_seed) begin
      s_d = seed_i;
    end else if (cmd_i.init_seed) begin
      s_d = (s_q[StateW-1] && neg[StateW-1] == 1'b0) ? neg : StateW'(1);
    end else if (cmd_i.red) begin
      s_d = {1'b0, red};
    end
  end

  always_comb begin
    last_d = last_q;
    if (cmd_i.ld_seed) begin
      last_d = '0;
    end else if (cmd_i.last_from_s) begin
      last_d = red;
    end else if (cmd_i.wr_draw) begin
      last_d = rdata;
    end
  end

  // Leading-zero search, one binary step per cycle.
  assign amt = ShW'(5'd1 << cmd_i.norm_k);
  always_comb begin
    norm_d = norm_q;
    sh_d   = sh_q;
    if (cmd_i.wr_draw) begin
      norm_d = rdata;
      sh_d   = '0;
    end else if (cmd_i.norm && ((norm_q >> (5'd31 - amt)) == '0)) begin
      norm_d = norm_q << amt;
      sh_d   = sh_q + amt;
    end
  end

  // word*(2^31+1) normalised is {norm, norm}; round to 53 bits.
  assign top53 = {norm_q, norm_q[WordW-1:9]};
  assign inc1  = norm_q[8] && ((norm_q[7:0] != '0) || norm_q[9]);

  // Round the double to single; a carry out of the double gives mantissa 1.0.
  assign keep24 = d_q[52:29];
  assign inc2   = d_q[28] && ((d_q[27:0] != '0) || d_q[29]);
  assign m25    = d_q[53] ? 25'h080_0000 : ({1'b0, keep24} + 25'(inc2));
  assign expo   = ExpBase - 8'(sh_q) + 8'(d_q[53]) + 8'(m25[24]);

  always_comb begin
    if (last_q == '0) begin
      fbits = '0;
    end else if (last_q >= ClampWord) begin
      fbits = ClampBits;
    end else begin
      fbits = {expo[6:0], m25[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(s_q[WordW-1:0]) * ProdW'(LehmerMul);
    end
    norm_q <= norm_d;
    sh_q   <= sh_d;
    if (cmd_i.rnd1) begin
      d_q <= {1'b0, top53} + DblW'(inc1);
    end
    if (cmd_i.out_load) begin
      word_q <= last_q;
      bits_q <= fbits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q         <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_q    <= s_d;
      last_q <= last_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign bits_o      = bits_q;
endmodule

@@ rtl/msu_checker.sv @@
// Port-level checks for the shuffled generator, bound to the top level.
// Depends on minstd_shuffle_unit_random.
module msu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] word_i,
  input logic [29:0] bits_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(word_i) && $stable(bits_i))
    else $error("result changed while stalled");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bits_i <= 30'h3F7F_FFFE)
    else $error("float bits above clamp");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((word_i == '0) == (bits_i == '0)))
    else $error("zero word and zero float disagree");

  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid straight after reset");
endmodule

bind minstd_shuffle_unit_random msu_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .word_i      (out_chan.random_word),
  .bits_i      (out_chan.unit_float_bits)
);

@@ verif/tb_minstd_shuffle_unit_random.sv @@
// Testbench for minstd_shuffle_unit_random: seed and draw transfers with
// random bursts and stalls, results checked against an in-bench generator model.
// Depends on msu_pkg, msu_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_minstd_shuffle_unit_random;
  import msu_pkg::*;

  localparam logic CmdDraw = 1'b0;
  localparam logic CmdSeed = 1'b1;
  localparam int unsigned Warmup    = 8;
  localparam int unsigned IdleLimit = 6000;
  localparam int unsigned TailWait  = 200;
  localparam real UnitScale = 4.656612875245797e-10;
  localparam real UnitClamp = 0.99999988;
  localparam logic [31:0] IndexDiv = 32'd67108864;  // 1 + (2^31-2)/32

  typedef struct {
    logic        command;
    logic [31:0] seed_value;
    bit          drain_first;  // hold off until every result has come
  } gen_cmd_t;

  typedef struct {
    logic [WordW-1:0]  word;
    logic [FloatW-1:0] fbits;
  } draw_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  msu_in_if  in_bus ();
  msu_out_if out_bus ();

  minstd_shuffle_unit_random #(.WarmupSteps(Warmup)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Pending commands and expected draw results
  gen_cmd_t  cmd_q[$];
  draw_res_t draw_q[$];

  // Model state of the generator
  logic [31:0]      mdl_state;
  logic [WordW-1:0] mdl_last;
  logic [WordW-1:0] mdl_table [TableDepth];

  int unsigned n_mismatch = 0;
  int unsigned n_in_xfer  = 0;
  bit          in_xfer    = 1'b0;
  bit          stim_done  = 1'b0;

  function automatic logic [31:0] lehmer_step(logic [31:0] s);
    logic [63:0] p;
    p = {33'd0, s[30:0]} * 64'd16807;
    return 32'(p % 64'h7FFF_FFFF);
  endfunction

  // word/(2^31-1) as double, rounded to single by hand (nearest, ties even)
  function automatic logic [FloatW-1:0] unit_float(logic [WordW-1:0] w);
    real         v;
    logic [63:0] d;
    logic [24:0] m;
    logic [10:0] e;
    logic [7:0]  fe;
    bit          up;
    v = real'(w) * UnitScale;
    if (v > UnitClamp) return ClampBits;
    if (w == '0) return '0;
    d  = $realtobits(v);
    e  = d[62:52];
    up = d[28] && ((|d[27:0]) || d[29]);
    m  = {1'b0, 1'b1, d[51:29]} + 25'(up);
    if (m[24]) begin
      m = m >> 1;
      e = e + 11'd1;
    end
    fe = 8'(e - 11'd1023 + 11'd127);
    return FloatW'({fe, m[22:0]});
  endfunction

  task automatic model_reset();
    mdl_state = '0;
    mdl_last  = '0;
    foreach (mdl_table[i]) mdl_table[i] = '0;
  endtask

  task automatic rebuild_table();
    logic [31:0] s;
    if (mdl_state[31] && mdl_state != 32'h8000_0000) s = -mdl_state;
    else s = 32'd1;
    for (int i = 0; i < Warmup + TableDepth; i++) begin
      s = lehmer_step(s);
      if (i >= Warmup) mdl_table[TableDepth - 1 - (i - Warmup)] = s[30:0];
    end
    mdl_state = s;
    mdl_last  = mdl_table[0];
  endtask

  // Apply one accepted command; a draw queues its expected result
  task automatic predict_cmd(logic command, logic [31:0] seed);
    logic [31:0] idx;
    draw_res_t   r;
    if (command == CmdSeed) begin
      mdl_state = seed;
      mdl_last  = '0;
      return;
    end
    if (mdl_state == '0 || mdl_state[31] || mdl_last == '0) rebuild_table();
    mdl_state = lehmer_step(mdl_state);
    idx = {1'b0, mdl_last} / IndexDiv;
    if (idx >= TableDepth) idx = TableDepth - 1;
    mdl_last = mdl_table[idx];
    mdl_table[idx] = mdl_state[30:0];
    r.word  = mdl_last;
    r.fbits = unit_float(mdl_last);
    draw_q.push_back(r);
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk_i) begin
    draw_res_t e;
    in_xfer <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_cmd(in_bus.command, in_bus.seed_value);
        n_in_xfer <= n_in_xfer + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (draw_q.size() == 0) begin
          n_mismatch = n_mismatch + 1;
          if (n_mismatch <= 10)
            $display("unexpected result: word %0d bits %h",
                     out_bus.random_word, out_bus.unit_float_bits);
        end else begin
          e = draw_q.pop_front();
          if (out_bus.random_word !== e.word || out_bus.unit_float_bits !== e.fbits) begin
            n_mismatch = n_mismatch + 1;
            if (n_mismatch <= 10)
              $display("mismatch: word exp %0d got %0d, bits exp %h got %h",
                       e.word, out_bus.random_word, e.fbits, out_bus.unit_float_bits);
          end
        end
      end
    end
  end

  // Driver: bursts of transfers with random gaps, updated on the falling edge
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    gen_cmd_t c;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_xfer) begin
      // offer held until transfer
    end else begin
      if (in_bus.valid) void'(cmd_q.pop_front());
      if (gap_left > 0) begin
        gap_left     = gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (cmd_q.size() == 0 ||
                   (cmd_q[0].drain_first && draw_q.size() != 0)) begin
        in_bus.valid <= 1'b0;
      end else begin
        c = cmd_q[0];
        cmd_q[0].drain_first = 1'b0;
        in_bus.valid      <= 1'b1;
        in_bus.command    <= c.command;
        in_bus.seed_value <= c.seed_value;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern changes every so often; one long hold-off
  int unsigned hold_left  = 0;
  int unsigned phase_left = 0;
  int unsigned stall_pct  = 0;
  bit          long_done  = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (!long_done && n_in_xfer >= 600) begin
        long_done = 1'b1;
        hold_left = 500;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 80;
          default: stall_pct = $urandom_range(10, 60);
        endcase
      end
      phase_left = phase_left - 1;
      if (hold_left > 0) begin
        hold_left     = hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_cmd(logic command, logic [31:0] seed, bit drain);
    gen_cmd_t c;
    c.command     = command;
    c.seed_value  = seed;
    c.drain_first = drain;
    cmd_q.push_back(c);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h8000_0001;   // state lands on the modulus
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] dir_seeds [7];
    in_bus.valid      = 1'b0;
    in_bus.command    = CmdDraw;
    in_bus.seed_value = '0;
    out_bus.ready     = 1'b0;
    model_reset();

    // Directed: draw straight from reset, then seeds at the extremes, each
    // followed by draws. Negative seeds but the most negative are negated; others restart from one.
    // The seed one above the most negative leaves the modulus as state, so
    // the draw yields a zero word and the next draw rebuilds the table.
    dir_seeds = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_BEEF};
    add_cmd(CmdDraw, 32'hFFFF_FFFF, 1'b0);
    foreach (dir_seeds[i]) begin
      add_cmd(CmdSeed, dir_seeds[i], 1'b0);
      add_cmd(CmdDraw, 32'hFFFF_FFFF, 1'b0);
      add_cmd(CmdDraw, 32'h0000_0000, 1'b0);
    end

    // Random: mostly draws with random ignored seed fields, sometimes reseeds
    for (int n = 0; n < 1950; n++) begin
      if ($urandom_range(0, 99) < 4) add_cmd(CmdSeed, pick_seed(), n == 1200);
      else add_cmd(CmdDraw, $urandom(), n == 1200);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_q.size() == 0 && !in_bus.valid);
    wait (draw_q.size() == 0);
    repeat (TailWait) @(posedge clk_i);
    if (n_mismatch == 0 && draw_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
